// File: rtl/core/red_pkg.sv
`default_nettype none
package red_pkg;

  localparam int TICK_COUNT_WIDTH = 20;
  localparam int CFG_TICK_W       = 20;
  localparam int ADDR_W           = 4;
  localparam int DATA_W           = 32;
  localparam int CMP_W            = 33;

  localparam logic [1:0] REG_ENCODER_TYPE      = 2'd0;
  localparam logic [1:0] REG_MOUSE_GUARD       = 2'd1;
  localparam logic [1:0] REG_MIN_SAMPLE_TICKS  = 2'd2;
  localparam logic [1:0] REG_MIN_REVERSE_TICKS = 2'd3;

  localparam logic [1:0] TYPE_ALL      = 2'd0;
  localparam logic [1:0] TYPE_MID      = 2'd1;
  localparam logic [1:0] TYPE_EDGES    = 2'd2;
  localparam logic [1:0] TYPE_ZERO     = 2'd3;

  localparam logic [1:0] DIR_UNKNOWN = 2'd0;
  localparam logic [1:0] DIR_UP      = 2'd1;
  localparam logic [1:0] DIR_DOWN    = 2'd2;

  typedef logic [TICK_COUNT_WIDTH-1:0] tick_t;

  typedef struct packed {
    logic [1:0]            encoder_type;
    logic                  mouse_guard_enable;
    logic [CFG_TICK_W-1:0] min_sample_ticks;
    logic [CFG_TICK_W-1:0] min_reverse_ticks;
  } cfg_t;

  typedef struct packed {
    logic       step_event;
    logic       direction_up;
    logic       sample_rejected;
    logic [1:0] phase_now;
  } res_t;

  function automatic logic is_detent(input logic [1:0] enc_type, input logic [1:0] ph);
    logic r;
    case (enc_type)
      TYPE_ALL:   r = 1'b1;
      TYPE_MID:   r = (ph == 2'd1) || (ph == 2'd2);
      TYPE_EDGES: r = (ph == 2'd0) || (ph == 2'd3);
      default:    r = (ph == 2'd0);
    endcase
    return r;
  endfunction

  function automatic logic [1:0] step_direction(input logic [1:0] from, input logic [1:0] to);
    logic [1:0] up_from;
    case (to)
      2'd0:    up_from = 2'd1;
      2'd1:    up_from = 2'd3;
      2'd2:    up_from = 2'd0;
      default: up_from = 2'd2;
    endcase
    return (from == up_from) ? DIR_UP : DIR_DOWN;
  endfunction

  function automatic tick_t tick_inc(input tick_t v);
    return (v == {TICK_COUNT_WIDTH{1'b1}}) ? v : v + tick_t'(1);
  endfunction

endpackage
`default_nettype wire

// File: rtl/core/red_ifs.sv
`default_nettype none
interface red_in_if;
  logic valid;
  logic ready;
  logic line_one_level;
  logic line_two_level;

  modport source (output valid, output line_one_level, output line_two_level, input ready);
  modport sink (input valid, input line_one_level, input line_two_level, output ready);
endinterface

interface red_out_if;
  logic       valid;
  logic       ready;
  logic       step_event;
  logic       direction_up;
  logic       sample_rejected;
  logic [1:0] phase_now;

  modport source (output valid, output step_event, output direction_up,
                  output sample_rejected, output phase_now, input ready);
  modport sink (input valid, input step_event, input direction_up,
                input sample_rejected, input phase_now, output ready);
endinterface
`default_nettype wire

// File: rtl/core/red_cfg.sv
`default_nettype none
module red_cfg (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      psel,
  input  wire logic                      penable,
  input  wire logic                      pwrite,
  input  wire logic [red_pkg::ADDR_W-1:0] paddr,
  input  wire logic [red_pkg::DATA_W-1:0] pwdata,
  output logic      [red_pkg::DATA_W-1:0] prdata,
  output red_pkg::cfg_t                  cfg
);
  import red_pkg::*;

  logic       wr;
  logic [1:0] idx;

  assign wr  = psel && penable && pwrite;
  assign idx = paddr[3:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (wr) begin
      case (idx)
        REG_ENCODER_TYPE:      cfg.encoder_type       <= pwdata[1:0];
        REG_MOUSE_GUARD:       cfg.mouse_guard_enable <= pwdata[0];
        REG_MIN_SAMPLE_TICKS:  cfg.min_sample_ticks   <= pwdata[CFG_TICK_W-1:0];
        REG_MIN_REVERSE_TICKS: cfg.min_reverse_ticks  <= pwdata[CFG_TICK_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_ENCODER_TYPE:      prdata = DATA_W'(cfg.encoder_type);
      REG_MOUSE_GUARD:       prdata = DATA_W'(cfg.mouse_guard_enable);
      REG_MIN_SAMPLE_TICKS:  prdata = DATA_W'(cfg.min_sample_ticks);
      REG_MIN_REVERSE_TICKS: prdata = DATA_W'(cfg.min_reverse_ticks);
      default:               prdata = '0;
    endcase
  end

endmodule
`default_nettype wire

// File: rtl/core/rotary_encoder_detent_decoder.sv
// Channel  Dir  Payload                                               Accept
// in_ch    in   line_one_level, line_two_level                        valid & ready
// out_ch   out  step_event, direction_up, sample_rejected, phase_now  valid & ready
// apb      in   encoder_type, mouse_guard_enable, min ticks (x2)      psel & penable & pwrite
//
// One request per cycle while ready is high; a taken request reaches out_ch through
// the input register and the result register that lie around the step logic.
// rst is synchronous and clears the pipeline, phase, counters and configuration registers.
// A stalled result holds in the output register while one more request waits in
// the input register; ready drops only when both are full.
`default_nettype none
module rotary_encoder_detent_decoder (
  input  wire logic                       clk,
  input  wire logic                       rst,
  red_in_if.sink                          in_ch,
  red_out_if.source                       out_ch,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [red_pkg::ADDR_W-1:0] paddr,
  input  wire logic [red_pkg::DATA_W-1:0] pwdata,
  output logic      [red_pkg::DATA_W-1:0] prdata,
  output logic                            pready
);
  import red_pkg::*;

  cfg_t       cfg;
  logic       s1_valid;
  logic [1:0] s1_phase;
  logic       s1_fire;
  logic       out_valid;
  res_t       out_res;

  logic       primed;
  logic [1:0] phase_reg;
  tick_t      ticks_since_accept;
  tick_t      ticks_since_event;
  logic [1:0] last_direction;

  logic       primed_next;
  logic [1:0] phase_reg_next;
  tick_t      ticks_since_accept_next;
  tick_t      ticks_since_event_next;
  logic [1:0] last_direction_next;
  res_t       res_next;

  tick_t      tsa_inc;
  tick_t      tse_inc;
  logic       mouse_rej;
  logic       interval_rej;
  logic [1:0] dir_new;
  logic [1:0] dir_out;

  red_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg     (cfg)
  );

  assign pready = 1'b1;

  assign s1_fire     = s1_valid && (!out_valid || out_ch.ready);
  assign in_ch.ready = !s1_valid || s1_fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_phase <= {in_ch.line_two_level, in_ch.line_one_level};
    end
  end

  always_comb begin
    tsa_inc      = tick_inc(ticks_since_accept);
    tse_inc      = tick_inc(ticks_since_event);
    mouse_rej    = cfg.mouse_guard_enable && (cfg.encoder_type == TYPE_EDGES) &&
                   ((phase_reg ^ s1_phase) == 2'b11);
    interval_rej = CMP_W'(tsa_inc) < CMP_W'(cfg.min_sample_ticks);
    dir_new      = step_direction(phase_reg, s1_phase);
    dir_out      = dir_new;

    primed_next             = 1'b1;
    phase_reg_next          = phase_reg;
    ticks_since_accept_next = tsa_inc;
    ticks_since_event_next  = tse_inc;
    last_direction_next     = last_direction;
    res_next                = '0;

    if (!primed) begin
      phase_reg_next          = s1_phase;
      ticks_since_accept_next = '0;
      ticks_since_event_next  = '0;
    end else if (mouse_rej || interval_rej) begin
      res_next.sample_rejected = 1'b1;
    end else begin
      ticks_since_accept_next = '0;
      phase_reg_next          = s1_phase;
      if ((s1_phase != phase_reg) && is_detent(cfg.encoder_type, s1_phase)) begin
        if (dir_new != last_direction) begin
          if (CMP_W'(tse_inc) < CMP_W'(cfg.min_reverse_ticks)) begin
            dir_out = last_direction;
          end else begin
            last_direction_next = dir_new;
          end
        end
        ticks_since_event_next = '0;
        res_next.step_event    = 1'b1;
        res_next.direction_up  = (dir_out == DIR_UP);
      end
    end
    res_next.phase_now = phase_reg_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      primed             <= 1'b0;
      phase_reg          <= '0;
      ticks_since_accept <= '0;
      ticks_since_event  <= '0;
      last_direction     <= DIR_UNKNOWN;
    end else if (s1_fire) begin
      primed             <= primed_next;
      phase_reg          <= phase_reg_next;
      ticks_since_accept <= ticks_since_accept_next;
      ticks_since_event  <= ticks_since_event_next;
      last_direction     <= last_direction_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_fire) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_res <= res_next;
    end
  end

  assign out_ch.valid           = out_valid;
  assign out_ch.step_event      = out_res.step_event;
  assign out_ch.direction_up    = out_res.direction_up;
  assign out_ch.sample_rejected = out_res.sample_rejected;
  assign out_ch.phase_now       = out_res.phase_now;

endmodule
`default_nettype wire

// File: rtl/core/red_chk.sv
`default_nettype none
module red_chk (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic       step_event,
  input wire logic       direction_up,
  input wire logic       sample_rejected,
  input wire logic [1:0] phase_now
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(phase_now) && $stable(step_event))
    else $error("stalled result changed");

  a_no_step_dir: assert property (@(posedge clk) disable iff (rst)
    out_valid && !step_event |-> !direction_up)
    else $error("direction set without step");

  a_step_xor_reject: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(step_event && sample_rejected))
    else $error("step and rejection together");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid && in_ready)
    else $error("pipeline not empty after reset");

  a_no_result_from_nothing: assert property (@(posedge clk) disable iff (rst)
    !out_valid && !$past(in_valid && in_ready) |=> !$rose(out_valid) || $past(in_valid, 2))
    else $error("result without request");

endmodule

bind rotary_encoder_detent_decoder red_chk u_red_chk (
  .clk             (clk),
  .rst             (rst),
  .in_valid        (in_ch.valid),
  .in_ready        (in_ch.ready),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .step_event      (out_ch.step_event),
  .direction_up    (out_ch.direction_up),
  .sample_rejected (out_ch.sample_rejected),
  .phase_now       (out_ch.phase_now)
);
`default_nettype wire
